// ===== rtl/cba_pkg.sv =====
// shared types and constants for the chunked bump allocator
`default_nettype none

package cba_pkg;

	// fixed field widths of the transactions
	localparam int REQ_W = 11;
	localparam int STATUS_W = 2;
	localparam int IDX_OUT_W = 4;
	localparam int OFF_W = 11;

	// status codes
	localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_CHUNK = 2'd2;

	// one result transaction
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_OUT_W-1:0] chunk_index;
		logic [OFF_W-1:0] slot_offset;
		logic opened_chunk;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/cba_used_mem.sv =====
// used-slot count memory, one write and one registered read port
`default_nettype none

module cba_used_mem #(
	parameter int DEPTH = 16,
	parameter int AW = 4,
	parameter int DW = 11
) (
	input wire logic clk,
	input wire logic rd_en,
	input wire logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input wire logic wr_en,
	input wire logic [AW-1:0] wr_addr,
	input wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cba_search.sv =====
// newest-to-oldest chunk search and grant sequencer
`default_nettype none

module cba_search
	import cba_pkg::*;
#(
	parameter int CHUNK_SLOTS = 1024,
	parameter int MAX_CHUNKS = 16,
	localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
	localparam int UW = $clog2(CHUNK_SLOTS + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire logic [REQ_W-1:0] request_size,
	output logic rd_en,
	output logic [IW-1:0] rd_addr,
	input wire logic [UW-1:0] rd_data,
	output logic wr_en,
	output logic [IW-1:0] wr_addr,
	output logic [UW-1:0] wr_data,
	output logic res_valid,
	input wire logic res_ready,
	output res_t res
);

	localparam int OW = $clog2(MAX_CHUNKS + 1);
	localparam int CW = ((UW > REQ_W) ? UW : REQ_W) + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN = 2'd2;

	localparam logic [CW-1:0] LIMIT = CW'(CHUNK_SLOTS);
	localparam logic [OW-1:0] MAX_OPEN = OW'(MAX_CHUNKS);

	logic [1:0] state_q;
	logic [REQ_W-1:0] n_q;
	logic big_q;
	logic hit_q;
	logic [UW-1:0] hit_used_q;
	logic [IW-1:0] idx_q;
	logic [OW-1:0] open_q;

	logic req_fire;
	logic res_fire;
	logic oversize;
	logic fit;
	logic room;
	logic [CW-1:0] used_c;

	assign req_stall = (state_q != S_IDLE);
	assign req_fire = req_valid && !req_stall;
	assign res_valid = (state_q == S_FIN);
	assign res_fire = res_valid && res_ready;

	assign oversize = CW'(request_size) > LIMIT;
	assign used_c = CW'(rd_data);
	assign fit = (used_c <= LIMIT) && ((LIMIT - used_c) >= CW'(n_q));
	assign room = open_q < MAX_OPEN;

	// read the newest chunk on accept, then one older chunk per cycle
	always_comb begin
		rd_en = 1'b0;
		rd_addr = idx_q;
		case (state_q)
			S_IDLE: begin
				rd_en = req_fire && !oversize && (open_q != '0);
				rd_addr = IW'(open_q - OW'(1));
			end
			S_SCAN: begin
				rd_en = !fit && (idx_q != '0);
				rd_addr = idx_q - IW'(1);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		res = '0;
		if (big_q) begin
			res.status = ST_TOO_LARGE;
		end else if (hit_q) begin
			res.status = ST_GRANTED;
			res.chunk_index = IDX_OUT_W'(idx_q);
			res.slot_offset = OFF_W'(hit_used_q);
		end else if (room) begin
			res.status = ST_GRANTED;
			res.chunk_index = IDX_OUT_W'(open_q);
			res.opened_chunk = 1'b1;
		end else begin
			res.status = ST_NO_CHUNK;
		end
	end

	// write-back at the end of the item, when the result is taken; no read is issued while the result is pending
	assign wr_en = res_fire && !big_q && (hit_q || room);
	assign wr_addr = hit_q ? idx_q : IW'(open_q);
	assign wr_data = hit_q ? (hit_used_q + UW'(n_q)) : UW'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			open_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						if (!oversize && (open_q != '0)) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					if (fit || (idx_q == '0)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
						if (!big_q && !hit_q && room) begin
							open_q <= open_q + OW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					n_q <= request_size;
					big_q <= oversize;
					hit_q <= 1'b0;
					idx_q <= IW'(open_q - OW'(1));
				end
			end
			S_SCAN: begin
				if (fit) begin
					hit_q <= 1'b1;
					hit_used_q <= rd_data;
				end else if (idx_q != '0) begin
					idx_q <= idx_q - IW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= MAX_OPEN)
		else $error("open chunk count above limit");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (OW'(idx_q) < open_q))
		else $error("search index outside open chunks");

	a_write_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_FIN) && !big_q)
		else $error("memory write outside result cycle");

	a_open_step: assert property (@(posedge clk) disable iff (!arst_n)
		(res_fire && res.opened_chunk) |=> (open_q == $past(open_q) + OW'(1)))
		else $error("opened chunk not counted");

	a_no_read_in_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> !rd_en)
		else $error("read issued while result pending");

endmodule

`default_nettype wire

// ===== rtl/chunked_bump_allocator.sv =====
// chunked bump allocator top level with result output register
//
// channel   | handshake               | payload
// ----------+-------------------------+-------------------------------------------------
// request   | req_valid / req_stall   | request_size
// result    | res_valid / res_stall   | status, chunk_index, slot_offset, opened_chunk
//
// after accept, a request reads the used counts of the open chunks newest to oldest,
// 1..MAX_CHUNKS of them, one chunk per cycle, until one fits or the oldest is read;
// oversize requests and requests with no chunk open skip the search and go straight
// to the result state
// reset clears the open-chunk count and control state; the used-count memory is not cleared
// the result register lets the next request enter while a result waits under res_stall
`default_nettype none

module chunked_bump_allocator
	import cba_pkg::*;
#(
	parameter int CHUNK_SLOTS = 1024,
	parameter int MAX_CHUNKS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire logic [REQ_W-1:0] request_size,
	output logic res_valid,
	input wire logic res_stall,
	output logic [STATUS_W-1:0] status,
	output logic [IDX_OUT_W-1:0] chunk_index,
	output logic [OFF_W-1:0] slot_offset,
	output logic opened_chunk
);

	localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int UW = $clog2(CHUNK_SLOTS + 1);

	// memory port between sequencer and used-count store
	logic rd_en;
	logic [IW-1:0] rd_addr;
	logic [UW-1:0] rd_data;
	logic wr_en;
	logic [IW-1:0] wr_addr;
	logic [UW-1:0] wr_data;

	// finished result from the sequencer
	logic seq_valid;
	logic seq_ready;
	res_t seq_res;

	// output register
	logic out_valid_q;
	res_t out_q;

	cba_used_mem #(
		.DEPTH(MAX_CHUNKS),
		.AW(IW),
		.DW(UW)
	) u_mem (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	cba_search #(
		.CHUNK_SLOTS(CHUNK_SLOTS),
		.MAX_CHUNKS(MAX_CHUNKS)
	) u_search (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.request_size(request_size),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.res_valid(seq_valid),
		.res_ready(seq_ready),
		.res(seq_res)
	);

	// the register takes a new result when empty or being drained this cycle
	assign seq_ready = !out_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_ready) begin
			out_valid_q <= seq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_valid && seq_ready) begin
			out_q <= seq_res;
		end
	end

	assign res_valid = out_valid_q;
	assign status = out_q.status;
	assign chunk_index = out_q.chunk_index;
	assign slot_offset = out_q.slot_offset;
	assign opened_chunk = out_q.opened_chunk;

endmodule

`default_nettype wire
